### src/prar_pkg.sv
// ----------------------------------------------------------------------------
// prar_pkg
// Shared types and constants for the point-about-axis rotation block.
// ----------------------------------------------------------------------------
package prar_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE   = 3'd0,
        REG_START_X = 3'd1,
        REG_START_Y = 3'd2,
        REG_START_Z = 3'd3,
        REG_END_X   = 3'd4,
        REG_END_Y   = 3'd5,
        REG_END_Z   = 3'd6
    } cfg_reg_t;

    // Q6.30 angle constants
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
    localparam int                 CORDIC_STEPS = 30;

    // truncated arctangent table, unsigned Q0.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

### src/point_rotate_about_axis_line_top.sv
// ----------------------------------------------------------------------------
// point_rotate_about_axis_line_top
// Rotates Q16.16 points about a configured line by a configured angle.
// ----------------------------------------------------------------------------
// Usage:
//   Write rotation_angle and the two axis points through the cfg port.
//   Every write (and reset) starts a matrix setup sequencer: difference,
//   normalize, sum of squares, bit-serial square root, three bit-serial
//   divides, a 30-step CORDIC and 12 shared multiplies; in_ready stays low
//   until the matrix is ready. Points enter on the in channel (valid/ready),
//   one beat per cycle while in_ready is high.
//   The point pipeline has four register stages: offset, 9 multiplies,
//   sum, round/saturate, each with its own valid bit. Throughput is one
//   point per cycle while out_ready is high, set by the per-stage multipliers.
//   When out_ready is low the stages fill behind the output register and
//   then in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits, loads the register reset values and starts
//   the setup sequencer. A coincident axis passes points through and sets
//   axis_degenerate.
// ----------------------------------------------------------------------------
module point_rotate_about_axis_line_top
    import prar_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_W-1:0]    point_x,
    input  logic signed [COORD_W-1:0]    point_y,
    input  logic signed [COORD_W-1:0]    point_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_W-1:0]    rotated_x,
    output logic signed [COORD_W-1:0]    rotated_y,
    output logic signed [COORD_W-1:0]    rotated_z,
    output logic                         axis_degenerate
);

    typedef enum logic [3:0] {
        ST_DIFF, ST_NORM, ST_SQ, ST_SQRT, ST_DIVLD, ST_DIV,
        ST_ANG, ST_FOLD, ST_CORDIC, ST_MUL, ST_MAT, ST_IDLE
    } setup_state_t;

    function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > Q30_ONE)
            r = 32'sd1073741824;
        else if (v < -Q30_ONE)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [31:0]        start_reg [3];
    logic signed [31:0]        end_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= '0;
            start_reg[0] <= '0;
            start_reg[1] <= '0;
            start_reg[2] <= '0;
            end_reg[0]   <= '0;
            end_reg[1]   <= '0;
            end_reg[2]   <= 32'sd65536;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ANGLE:   angle_reg    <= cfg_wdata[ANGLE_W-1:0];
                REG_START_X: start_reg[0] <= cfg_wdata;
                REG_START_Y: start_reg[1] <= cfg_wdata;
                REG_START_Z: start_reg[2] <= cfg_wdata;
                REG_END_X:   end_reg[0]   <= cfg_wdata;
                REG_END_Y:   end_reg[1]   <= cfg_wdata;
                REG_END_Z:   end_reg[2]   <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // ---------------- setup sequencer ----------------
    setup_state_t state_reg;
    logic [1:0]   cnt_reg;
    logic [5:0]   step_reg;
    logic         degen_reg;

    logic signed [32:0] d_w     [3];
    logic signed [32:0] nd_w    [3];
    logic [31:0]        mag_in  [3];
    logic [31:0]        mx_in;
    logic               degen_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_w[i]    = {end_reg[i][31], end_reg[i]} - {start_reg[i][31], start_reg[i]};
            nd_w[i]   = -d_w[i];
            mag_in[i] = d_w[i][32] ? nd_w[i][31:0] : d_w[i][31:0];
        end
        mx_in = mag_in[0];
        if (mag_in[1] > mx_in)
            mx_in = mag_in[1];
        if (mag_in[2] > mx_in)
            mx_in = mag_in[2];
        degen_in = (d_w[0] == '0) && (d_w[1] == '0) && (d_w[2] == '0);
    end

    logic [31:0]        mag_reg  [3];
    logic [31:0]        mx_reg;
    logic [2:0]         dneg_reg;
    logic [61:0]        n_reg;
    logic [62:0]        res_reg;
    logic [62:0]        bit_reg;
    logic [60:0]        num_reg;
    logic [30:0]        rem_reg;
    logic [32:0]        q_reg;
    logic signed [31:0] u_reg    [3];
    logic signed [35:0] z_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [65:0] prod_reg;
    logic signed [33:0] pr_reg   [12];
    logic signed [31:0] m_reg    [9];

    logic [29:0]        mag_sel;
    logic [59:0]        sq_w;
    logic [62:0]        sqrt_try;
    logic [30:0]        norm_w;
    logic [31:0]        rem_sh;
    logic               div_ge;
    logic [30:0]        rem_next;
    logic [32:0]        q_next;
    logic [30:0]        uq_w;
    logic signed [31:0] u_new;
    logic signed [35:0] a_ext;
    logic [4:0]         sh_w;
    logic signed [33:0] xs_w;
    logic signed [33:0] ys_w;
    logic signed [35:0] atan_w;
    logic signed [31:0] s_val;
    logic signed [31:0] c_val;
    logic signed [33:0] t_val;
    logic signed [33:0] op_a;
    logic signed [31:0] op_b;
    logic signed [65:0] rnd_w;
    logic [3:0]         pr_idx;
    logic signed [35:0] c_ext;

    always_comb
    begin
        mag_sel  = mag_reg[cnt_reg][29:0];
        sq_w     = mag_sel * mag_sel;
        sqrt_try = res_reg + bit_reg;
        norm_w   = res_reg[30:0];
        rem_sh   = {rem_reg, num_reg[60]};
        div_ge   = rem_sh >= {1'b0, norm_w};
        rem_next = div_ge ? 31'(rem_sh - {1'b0, norm_w}) : rem_sh[30:0];
        q_next   = {q_reg[31:0], div_ge};
        uq_w     = (q_next > 33'd1073741824) ? 31'd1073741824 : q_next[30:0];
        u_new    = dneg_reg[cnt_reg] ? -$signed({1'b0, uq_w}) : $signed({1'b0, uq_w});
        a_ext    = {{2{angle_reg[ANGLE_W-1]}}, angle_reg, 18'b0};
        sh_w     = step_reg[4:0];
        xs_w     = x_reg >>> sh_w;
        ys_w     = y_reg >>> sh_w;
        atan_w   = $signed({6'b0, atan_q30(sh_w)});
        s_val    = clamp_q30(neg_reg ? -{{2{y_reg[33]}}, y_reg} : {{2{y_reg[33]}}, y_reg});
        c_val    = clamp_q30(neg_reg ? -{{2{x_reg[33]}}, x_reg} : {{2{x_reg[33]}}, x_reg});
        c_ext    = {{4{c_val[31]}}, c_val};
        t_val    = 34'sd1073741824 - {{2{c_val[31]}}, c_val};
        rnd_w    = prod_reg + 66'sd536870912;
        pr_idx   = step_reg[3:0] - 4'd1;
        case (step_reg[3:0])
            4'd0:    begin op_a = t_val;     op_b = u_reg[0]; end
            4'd1:    begin op_a = t_val;     op_b = u_reg[1]; end
            4'd2:    begin op_a = t_val;     op_b = u_reg[2]; end
            4'd3:    begin op_a = pr_reg[0]; op_b = u_reg[0]; end
            4'd4:    begin op_a = pr_reg[0]; op_b = u_reg[1]; end
            4'd5:    begin op_a = pr_reg[0]; op_b = u_reg[2]; end
            4'd6:    begin op_a = pr_reg[1]; op_b = u_reg[1]; end
            4'd7:    begin op_a = pr_reg[1]; op_b = u_reg[2]; end
            4'd8:    begin op_a = pr_reg[2]; op_b = u_reg[2]; end
            4'd9:    begin op_a = {{2{u_reg[0][31]}}, u_reg[0]}; op_b = s_val; end
            4'd10:   begin op_a = {{2{u_reg[1][31]}}, u_reg[1]}; op_b = s_val; end
            4'd11:   begin op_a = {{2{u_reg[2][31]}}, u_reg[2]}; op_b = s_val; end
            default: begin op_a = '0;        op_b = '0;       end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DIFF;
            cnt_reg   <= '0;
            step_reg  <= '0;
            degen_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            state_reg <= ST_DIFF;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_DIFF:
                begin
                    degen_reg <= degen_in;
                    state_reg <= degen_in ? ST_IDLE : ST_NORM;
                end
                ST_NORM:
                begin
                    if (mx_reg >= 32'h2000_0000 && mx_reg < 32'h4000_0000)
                    begin
                        state_reg <= ST_SQ;
                        cnt_reg   <= '0;
                    end
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg[0])
                        state_reg <= ST_DIVLD;
                end
                ST_DIVLD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd60)
                    begin
                        if (cnt_reg == 2'd2)
                            state_reg <= ST_ANG;
                        else
                        begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= ST_DIVLD;
                        end
                    end
                end
                ST_ANG:
                    state_reg <= ST_FOLD;
                ST_FOLD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(CORDIC_STEPS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd12)
                        state_reg <= ST_MAT;
                end
                ST_MAT:
                    state_reg <= ST_IDLE;
                ST_IDLE:
                    ;
                default:
                    state_reg <= ST_DIFF;
            endcase
        end
    end

    // setup datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i]  <= mag_in[i];
                    dneg_reg[i] <= d_w[i][32];
                end
                mx_reg <= mx_in;
            end
            ST_NORM:
            begin
                if (mx_reg < 32'h2000_0000)
                begin
                    mx_reg <= mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
                else if (mx_reg >= 32'h4000_0000)
                begin
                    mx_reg <= mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
            end
            ST_SQ:
            begin
                n_reg   <= (cnt_reg == 2'd0) ? {2'b0, sq_w} : n_reg + {2'b0, sq_w};
                res_reg <= '0;
                bit_reg <= {1'b1, 62'b0};
            end
            ST_SQRT:
            begin
                if ({1'b0, n_reg} >= sqrt_try)
                begin
                    n_reg   <= 62'({1'b0, n_reg} - sqrt_try);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            ST_DIVLD:
            begin
                num_reg <= {1'b0, mag_sel, 30'b0} + {31'b0, norm_w[30:1]};
                rem_reg <= '0;
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                num_reg <= num_reg << 1;
                rem_reg <= rem_next;
                q_reg   <= q_next;
                if (step_reg == 6'd60)
                    u_reg[cnt_reg] <= u_new;
            end
            ST_ANG:
            begin
                if (a_ext > PI_Q30)
                    z_reg <= a_ext - TWO_PI_Q30;
                else if (a_ext < -PI_Q30)
                    z_reg <= a_ext + TWO_PI_Q30;
                else
                    z_reg <= a_ext;
            end
            ST_FOLD:
            begin
                // fold into [-pi/2, pi/2]; signs flip at the end
                if (z_reg > HALF_PI_Q30)
                begin
                    z_reg   <= z_reg - PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (z_reg < -HALF_PI_Q30)
                begin
                    z_reg   <= z_reg + PI_Q30;
                    neg_reg <= 1'b1;
                end
                else
                    neg_reg <= 1'b0;
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
            end
            ST_CORDIC:
            begin
                if (!z_reg[35])
                begin
                    x_reg <= x_reg - ys_w;
                    y_reg <= y_reg + xs_w;
                    z_reg <= z_reg - atan_w;
                end
                else
                begin
                    x_reg <= x_reg + ys_w;
                    y_reg <= y_reg - xs_w;
                    z_reg <= z_reg + atan_w;
                end
            end
            ST_MUL:
            begin
                // multiply one step, round and store the previous one
                prod_reg <= op_a * op_b;
                if (step_reg != 6'd0)
                    pr_reg[pr_idx] <= rnd_w[63:30];
            end
            ST_MAT:
            begin
                m_reg[0] <= clamp_q30(c_ext + pr_reg[3]);
                m_reg[1] <= clamp_q30(36'(pr_reg[4]) - 36'(pr_reg[11]));
                m_reg[2] <= clamp_q30(36'(pr_reg[5]) + 36'(pr_reg[10]));
                m_reg[3] <= clamp_q30(36'(pr_reg[4]) + 36'(pr_reg[11]));
                m_reg[4] <= clamp_q30(c_ext + pr_reg[6]);
                m_reg[5] <= clamp_q30(36'(pr_reg[7]) - 36'(pr_reg[9]));
                m_reg[6] <= clamp_q30(36'(pr_reg[5]) - 36'(pr_reg[10]));
                m_reg[7] <= clamp_q30(36'(pr_reg[7]) + 36'(pr_reg[9]));
                m_reg[8] <= clamp_q30(c_ext + pr_reg[8]);
            end
            default:
                ;
        endcase
    end

    // ---------------- point pipeline ----------------
    logic               vld1_reg, vld2_reg, vld3_reg, out_valid_reg;
    logic               rdy1, rdy2, rdy3, rdy4;
    logic               in_fire;
    logic signed [32:0] v1_reg   [3];
    logic signed [31:0] p1_reg   [3];
    logic signed [64:0] mp2_reg  [9];
    logic signed [31:0] p2_reg   [3];
    logic signed [64:0] acc3_reg [3];
    logic signed [31:0] p3_reg   [3];
    logic signed [31:0] rot_reg  [3];
    logic               degen_out_reg;
    logic signed [31:0] p_in     [3];
    logic signed [64:0] acc_w    [3];
    logic signed [37:0] r_w      [3];
    logic signed [31:0] sat_w    [3];

    assign rdy4     = !out_valid_reg || out_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1 && (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        p_in[0] = point_x;
        p_in[1] = point_y;
        p_in[2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            acc_w[i] = (mp2_reg[3*i] >>> 2) + (mp2_reg[3*i+1] >>> 2)
                     + (mp2_reg[3*i+2] >>> 2);
            r_w[i]   = 38'(((acc3_reg[i] + 65'sd134217728) >>> 28))
                     + 38'(start_reg[i]);
            if (r_w[i] > 38'sd2147483647)
                sat_w[i] = 32'sh7FFF_FFFF;
            else if (r_w[i] < -38'sd2147483648)
                sat_w[i] = 32'sh8000_0000;
            else
                sat_w[i] = r_w[i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                vld1_reg <= in_fire;
            if (rdy2)
                vld2_reg <= vld1_reg;
            if (rdy3)
                vld3_reg <= vld2_reg;
            if (rdy4)
                out_valid_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= p_in[i];
                v1_reg[i] <= {p_in[i][31], p_in[i]} - {start_reg[i][31], start_reg[i]};
            end
        end
        if (rdy2 && vld1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p2_reg[i] <= p1_reg[i];
                for (int j = 0; j < 3; j++)
                    mp2_reg[3*i+j] <= m_reg[3*i+j] * v1_reg[j];
            end
        end
        if (rdy3 && vld2_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p3_reg[i]   <= p2_reg[i];
                acc3_reg[i] <= acc_w[i];
            end
        end
        if (rdy4 && vld3_reg)
        begin
            for (int i = 0; i < 3; i++)
                rot_reg[i] <= degen_reg ? p3_reg[i] : sat_w[i];
            degen_out_reg <= degen_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rotated_x       = rot_reg[0];
    assign rotated_y       = rot_reg[1];
    assign rotated_z       = rot_reg[2];
    assign axis_degenerate = degen_out_reg;

endmodule

### src/prar_checker.sv
// ----------------------------------------------------------------------------
// prar_checker
// Port-level checks for point_rotate_about_axis_line_top.
// ----------------------------------------------------------------------------
module prar_checker
    import prar_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_wr_en,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] rotated_x,
    input logic signed [COORD_W-1:0] rotated_y,
    input logic signed [COORD_W-1:0] rotated_z,
    input logic                      axis_degenerate
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rotated_x)
            && $stable(rotated_y) && $stable(rotated_z) && $stable(axis_degenerate))
        else $error("result beat changed while stalled");

    // a register write restarts matrix setup, so no point is taken next cycle
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_ready)
        else $error("input accepted during matrix setup");

    // a cycle in reset leaves nothing offered and nothing taken
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_ready)
        else $error("handshake active in reset");

endmodule

bind point_rotate_about_axis_line_top prar_checker u_prar_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .rotated_x       (rotated_x),
    .rotated_y       (rotated_y),
    .rotated_z       (rotated_z),
    .axis_degenerate (axis_degenerate)
);
